// File: design/ptpd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the perspective point transform.
// Holds the transfer payload structs, register reset values and divider sizes.
package ptpd_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_COUNT     = 8;
  localparam int CFG_IDX_W     = 4;
  localparam int QBITS         = 33;

  localparam logic [63:0] CFG_RESET [CFG_COUNT] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
  };

  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               w_was_zero;
    logic               saturated;
  } out_t;

endpackage

// File: design/point_transform_perspective_divide_top.sv
`timescale 1ns / 1ps
// Top level of the 4x4 homogeneous point transform with perspective divide.
// Depends on ptpd_pkg for payload types, register resets and divider sizes.

// The block accepts one point per clock while in_stall is low and returns one
// result per point, in order. Its stages are one for the multipliers, two for the
// column sums and reduction, two to form magnitudes and the divider seed, 33 stages
// of a one-bit-per-stage restoring divider, and one output register. Empty stages
// close up under a stall, so the input keeps taking transfers while a finished result
// waits at the output. The user must write configuration only while idle (unchecked).
module point_transform_perspective_divide_top #(
  parameter int FRAC_BITS = ptpd_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  ptpd_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output ptpd_pkg::out_t                     out_data,
  input  logic                               cfg_write,
  input  logic [ptpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [63:0]                        cfg_data
);
  import ptpd_pkg::*;

  localparam int SW     = 66;
  localparam int VW     = SW - FRAC_BITS;
  localparam int RW     = VW + 1;
  localparam int NST    = QBITS + 6;
  localparam int CFG_AW = $clog2(CFG_COUNT);

  typedef struct packed {
    logic [2:0][RW-1:0]    rem;
    logic [2:0][QBITS-1:0] num;
    logic [2:0][QBITS-1:0] q;
    logic [VW-1:0]         d;
    logic [2:0]            neg;
    logic [2:0]            ovf;
    logic                  zero;
    logic [2:0][31:0]      zres;
    logic                  zsat;
  } div_t;

  logic [63:0]        cfg [CFG_COUNT];
  logic signed [31:0] m [4][4];
  logic [NST-1:0]     v;
  logic [NST-1:0]     adv;

  logic signed [63:0]   p0 [4];
  logic signed [63:0]   p1 [4];
  logic signed [63:0]   p2 [4];
  logic signed [SW-1:0] t [4];
  logic signed [SW-1:0] a [4];
  logic signed [SW-1:0] b [4];
  logic signed [SW-1:0] s2 [4];
  logic signed [VW-1:0] red [4];

  logic [VW-1:0]        mag3 [3];
  logic [VW-1:0]        d3;
  logic [2:0]           neg3;
  logic                 zero3;
  logic [2:0][31:0]     zres3;
  logic                 zsat3;

  logic [VW-1:0]        mag_c [3];
  logic [VW-1:0]        d_c;
  logic [2:0]           neg_c;
  logic [2:0][31:0]     zres_c;
  logic [2:0]           zsat_c;

  div_t dp [QBITS+1];
  div_t seed_c;
  out_t res_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write && cfg_index < CFG_IDX_W'(CFG_COUNT)) begin
      cfg[cfg_index[CFG_AW-1:0]] <= cfg_data;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        m[r][c] = cfg[2*r + c/2][32*(c%2) +: 32];
      end
    end
  end

  always_comb begin
    adv[NST-1] = !v[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int c = 0; c < 4; c++) begin
        p0[c] <= 64'(in_data.in_x) * 64'(m[0][c]);
        p1[c] <= 64'(in_data.in_y) * 64'(m[1][c]);
        p2[c] <= 64'(in_data.in_z) * 64'(m[2][c]);
        t[c]  <= SW'(m[3][c]) <<< FRAC_BITS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int c = 0; c < 4; c++) begin
        a[c] <= SW'(p0[c]) + SW'(p1[c]);
        b[c] <= SW'(p2[c]) + t[c];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      s2[c] = a[c] + b[c];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int c = 0; c < 4; c++) begin
        red[c] <= s2[c][SW-1:FRAC_BITS];
      end
    end
  end

  always_comb begin
    d_c = red[3][VW-1] ? VW'(-red[3]) : VW'(red[3]);
    for (int c = 0; c < 3; c++) begin
      mag_c[c]  = red[c][VW-1] ? VW'(-red[c]) : VW'(red[c]);
      neg_c[c]  = red[c][VW-1] ^ red[3][VW-1];
      zsat_c[c] = !((&red[c][VW-1:31]) || !(|red[c][VW-1:31]));
      if (!zsat_c[c]) begin
        zres_c[c] = red[c][31:0];
      end else if (red[c][VW-1]) begin
        zres_c[c] = SAT_MIN;
      end else begin
        zres_c[c] = SAT_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int c = 0; c < 3; c++) begin
        mag3[c] <= mag_c[c];
      end
      d3    <= d_c;
      neg3  <= neg_c;
      zero3 <= (red[3] == '0);
      zres3 <= zres_c;
      zsat3 <= |zsat_c;
    end
  end

  always_comb begin
    logic [SW-1:0] n;
    seed_c = '0;
    for (int c = 0; c < 3; c++) begin
      n              = {mag3[c], {FRAC_BITS{1'b0}}};
      seed_c.rem[c]  = RW'(n[SW-1:QBITS]);
      seed_c.num[c]  = n[QBITS-1:0];
      seed_c.ovf[c]  = RW'(n[SW-1:QBITS]) >= RW'(d3);
    end
    seed_c.d    = d3;
    seed_c.neg  = neg3;
    seed_c.zero = zero3;
    seed_c.zres = zres3;
    seed_c.zsat = zsat3;
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      dp[0] <= seed_c;
    end
  end

  for (genvar k = 0; k < QBITS; k++) begin : g_div
    div_t          nxt;
    logic [RW-1:0] r2;

    always_comb begin
      nxt = dp[k];
      r2  = '0;
      for (int c = 0; c < 3; c++) begin
        r2 = {dp[k].rem[c][RW-2:0], dp[k].num[c][QBITS-1]};
        nxt.num[c] = {dp[k].num[c][QBITS-2:0], 1'b0};
        if (r2 >= RW'(dp[k].d)) begin
          nxt.rem[c] = r2 - RW'(dp[k].d);
          nxt.q[c]   = {dp[k].q[c][QBITS-2:0], 1'b1};
        end else begin
          nxt.rem[c] = r2;
          nxt.q[c]   = {dp[k].q[c][QBITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv[5+k]) begin
        dp[k+1] <= nxt;
      end
    end
  end

  always_comb begin
    logic [2:0][31:0] r;
    logic [2:0]       s;
    logic [QBITS-1:0] q;
    for (int c = 0; c < 3; c++) begin
      q    = dp[QBITS].q[c];
      s[c] = 1'b0;
      if (dp[QBITS].zero) begin
        r[c] = dp[QBITS].zres[c];
      end else if (dp[QBITS].ovf[c]) begin
        r[c] = dp[QBITS].neg[c] ? SAT_MIN : SAT_MAX;
        s[c] = 1'b1;
      end else if (dp[QBITS].neg[c]) begin
        if (q > QBITS'(64'h8000_0000)) begin
          r[c] = SAT_MIN;
          s[c] = 1'b1;
        end else begin
          r[c] = -q[31:0];
        end
      end else if (q > QBITS'(64'h7fff_ffff)) begin
        r[c] = SAT_MAX;
        s[c] = 1'b1;
      end else begin
        r[c] = q[31:0];
      end
    end
    res_c.out_x      = r[0];
    res_c.out_y      = r[1];
    res_c.out_z      = r[2];
    res_c.w_was_zero = dp[QBITS].zero;
    res_c.saturated  = dp[QBITS].zero ? dp[QBITS].zsat : |s;
  end

  always_ff @(posedge clk) begin
    if (adv[NST-1]) begin
      out_data <= res_c;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output stage could move");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> v[0])
    else $error("accepted transfer did not enter the first stage");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    (v[NST-2] && dp[QBITS].zero && adv[NST-1]) |=> out_data.w_was_zero)
    else $error("zero w flag lost at the output register");

  a_ovf_saturates: assert property (@(posedge clk) disable iff (rst)
    (v[NST-2] && !dp[QBITS].zero && (|dp[QBITS].ovf) && adv[NST-1])
      |=> out_data.saturated)
    else $error("divider overflow did not raise the saturation flag");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for point_transform_perspective_divide_top.
// Predicts each transformed point from a local copy of the matrix and checks results in order.
// Depends on ptpd_pkg and the top level of the block.
module tb;
  import ptpd_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int DRAIN_CYCLES = QBITS + 20;
  localparam int CYCLE_LIMIT = 400000;

  localparam int REG_ROW1_FIRST  = 0;
  localparam int REG_ROW1_SECOND = 1;
  localparam int REG_ROW2_FIRST  = 2;
  localparam int REG_ROW2_SECOND = 3;
  localparam int REG_ROW3_FIRST  = 4;
  localparam int REG_ROW3_SECOND = 5;
  localparam int REG_ROW4_FIRST  = 6;
  localparam int REG_ROW4_SECOND = 7;

  localparam logic [31:0] Q_ONE = 32'h0001_0000;
  localparam logic [31:0] Q_NEG_LSB = 32'hffff_ffff;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  logic [63:0] matrix_regs [CFG_COUNT];
  out_t expected_points [$];
  int mismatches = 0;
  int cycles = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;

  point_transform_perspective_divide_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  function automatic logic signed [31:0] matrix_entry(int r, int c);
    logic [63:0] word;
    word = matrix_regs[2 * r + c / 2];
    return (c % 2) ? word[63:32] : word[31:0];
  endfunction

  function automatic out_t transform_point(in_t p);
    logic signed [127:0] coord [3];
    logic signed [127:0] reduced [4];
    logic signed [127:0] acc;
    logic signed [127:0] r;
    logic signed [127:0] m;
    logic signed [31:0] lanes [3];
    out_t res;
    coord[0] = p.in_x;
    coord[1] = p.in_y;
    coord[2] = p.in_z;
    for (int c = 0; c < 4; c++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) begin
        m = matrix_entry(k, c);
        acc = acc + coord[k] * m;
      end
      m = matrix_entry(3, c);
      acc = acc + (m <<< FB);
      reduced[c] = acc >>> FB;
    end
    res = '0;
    res.w_was_zero = (reduced[3] == 0);
    for (int c = 0; c < 3; c++) begin
      r = res.w_was_zero ? reduced[c] : (reduced[c] <<< FB) / reduced[3];
      if (r > 128'sd2147483647) begin
        lanes[c] = SAT_MAX;
        res.saturated = 1'b1;
      end else if (r < -128'sd2147483648) begin
        lanes[c] = SAT_MIN;
        res.saturated = 1'b1;
      end else begin
        lanes[c] = r[31:0];
      end
    end
    res.out_x = lanes[0];
    res.out_y = lanes[1];
    res.out_z = lanes[2];
    return res;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, out_data);
        mismatches++;
      end else begin
        want = expected_points.pop_front();
        if (out_data.out_x !== want.out_x)
          $display("%0t: out_x expected %h actual %h", $time, want.out_x, out_data.out_x);
        if (out_data.out_y !== want.out_y)
          $display("%0t: out_y expected %h actual %h", $time, want.out_y, out_data.out_y);
        if (out_data.out_z !== want.out_z)
          $display("%0t: out_z expected %h actual %h", $time, want.out_z, out_data.out_z);
        if (out_data.w_was_zero !== want.w_was_zero)
          $display("%0t: w_was_zero expected %b actual %b", $time, want.w_was_zero,
                   out_data.w_was_zero);
        if (out_data.saturated !== want.saturated)
          $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                   out_data.saturated);
        if (out_data !== want) mismatches++;
      end
    end
  end

  task automatic send_point(in_t p);
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_points.push_back(transform_point(p));
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(int idx, logic [63:0] value);
    cfg_write <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data <= value;
    if (idx < CFG_COUNT) matrix_regs[idx] = value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic load_matrix(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
                             logic [63:0] r3, logic [63:0] r4, logic [63:0] r5,
                             logic [63:0] r6, logic [63:0] r7);
    drain_pipeline();
    write_register(REG_ROW1_FIRST, r0);
    write_register(REG_ROW1_SECOND, r1);
    write_register(REG_ROW2_FIRST, r2);
    write_register(REG_ROW2_SECOND, r3);
    write_register(REG_ROW3_FIRST, r4);
    write_register(REG_ROW3_SECOND, r5);
    write_register(REG_ROW4_FIRST, r6);
    write_register(REG_ROW4_SECOND, r7);
  endtask

  function automatic logic [31:0] random_entry();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      2: return $urandom_range(0, 32'h0000_4000) - 32'h0000_2000;
      default: return 32'h0;
    endcase
  endfunction

  function automatic in_t random_point();
    in_t p;
    case ($urandom_range(3))
      0: p = {$urandom(), $urandom(), $urandom()};
      1: p = {$urandom_range(0, 32'h0200_0000) - 32'h0100_0000,
              $urandom_range(0, 32'h0200_0000) - 32'h0100_0000,
              $urandom_range(0, 32'h0200_0000) - 32'h0100_0000};
      2: p = {$urandom_range(0, 32'h0004_0000) - 32'h0002_0000,
              $urandom_range(0, 32'h0004_0000) - 32'h0002_0000,
              $urandom_range(0, 32'h0004_0000) - 32'h0002_0000};
      default: p = {SAT_MIN, SAT_MAX, 32'h0};
    endcase
    return p;
  endfunction

  task automatic load_random_matrix(bit zero_w);
    logic [63:0] regs [CFG_COUNT];
    for (int i = 0; i < CFG_COUNT; i++) regs[i] = {random_entry(), random_entry()};
    if (zero_w) begin
      regs[REG_ROW1_SECOND][63:32] = '0;
      regs[REG_ROW2_SECOND][63:32] = '0;
      regs[REG_ROW3_SECOND][63:32] = '0;
      regs[REG_ROW4_SECOND][63:32] = '0;
    end else if ($urandom_range(1)) begin
      regs[REG_ROW4_SECOND][63:32] = $urandom_range(Q_ONE / 4, Q_ONE * 4);
    end
    load_matrix(regs[0], regs[1], regs[2], regs[3], regs[4], regs[5], regs[6], regs[7]);
  endtask

  task automatic test_reset_identity();
    for (int i = 0; i < CFG_COUNT; i++) matrix_regs[i] = CFG_RESET[i];
    send_point('0);
    send_point({SAT_MAX, SAT_MAX, SAT_MAX});
    send_point({SAT_MIN, SAT_MIN, SAT_MIN});
    send_point({SAT_MIN, SAT_MAX, Q_ONE});
    send_point({32'h0001_8000, 32'hfffe_8000, 32'h0000_0001});
  endtask

  task automatic test_special_cases();
    // Column four all zero, so every point leaves w at zero.
    load_matrix(CFG_RESET[0], 64'h0, CFG_RESET[2], 64'h0, 64'h0, {32'h0, Q_ONE},
                {32'h0003_0000, 32'hfffd_0000}, 64'h0);
    send_point({32'h0001_0000, 32'h0002_0000, 32'h0003_0000});
    send_point({SAT_MAX, SAT_MIN, SAT_MAX});
    // A w sum just below zero floors to minus one LSB and still divides.
    load_matrix({32'h0, Q_ONE}, {Q_NEG_LSB, 32'h0}, CFG_RESET[2], 64'h0, 64'h0,
                {32'h0, Q_ONE}, 64'h0, 64'h0);
    send_point({32'h0000_0001, 32'h0000_0002, 32'h0000_0003});
    send_point({32'h0000_0001, 32'h0000_0000, 32'h0000_0000});
    // One LSB of w blows the divide out of range.
    load_matrix(CFG_RESET[0], 64'h0, CFG_RESET[2], 64'h0, 64'h0, CFG_RESET[5], 64'h0,
                {32'h0000_0001, 32'h0});
    send_point({32'h0001_0000, 32'hffff_0000, 32'h0});
    send_point({32'h0, 32'h0, 32'h0000_0001});
    // Writes past the last register must be ignored.
    drain_pipeline();
    write_register(CFG_COUNT, 64'hffff_ffff_ffff_ffff);
    write_register(CFG_COUNT + 7, 64'h8000_0000_8000_0000);
    send_point({32'h0000_8000, 32'h0, 32'hffff_8000});
  endtask

  task automatic test_register_extremes();
    load_matrix({8{8'hff}}, {8{8'hff}}, {8{8'hff}}, {8{8'hff}},
                {8{8'hff}}, {8{8'hff}}, {8{8'hff}}, {8{8'hff}});
    send_point({SAT_MAX, SAT_MIN, SAT_MAX});
    send_point({32'h0001_0000, 32'h0, 32'h0});
    load_matrix({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}},
                {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
    send_point({SAT_MIN, SAT_MIN, SAT_MIN});
    send_point({SAT_MAX, SAT_MAX, SAT_MAX});
    load_matrix({SAT_MIN, SAT_MAX}, {SAT_MAX, SAT_MIN}, {SAT_MIN, SAT_MAX}, {SAT_MAX, SAT_MIN},
                {SAT_MAX, SAT_MIN}, {SAT_MIN, SAT_MAX}, {SAT_MIN, SAT_MAX}, {Q_ONE, SAT_MAX});
    send_point({SAT_MAX, SAT_MIN, 32'h0001_0000});
    send_point('0);
  endtask

  task automatic test_random_stream(int count, int src_pct, int sink_pct);
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) load_random_matrix($urandom_range(5) == 0);
      send_point(random_point());
    end
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    load_random_matrix(1'b0);
    hold_request = 1'b1;
    for (int i = 0; i < 80; i++) send_point(random_point());
  endtask

  initial begin
    for (int i = 0; i < CFG_COUNT; i++) matrix_regs[i] = CFG_RESET[i];
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_identity();
    test_special_cases();
    test_register_extremes();
    test_random_stream(180, 9, 85);
    test_random_stream(180, 85, 9);
    test_backpressure();
    test_random_stream(110, 0, 0);
    drain_pipeline();
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// File: files.f
design/ptpd_pkg.sv
design/point_transform_perspective_divide_top.sv
tb/sv/tb.sv
